// ===== rtl/core/srbo_pkg.sv =====
// Package for the sample ring buffer: word types, command codes and sizes.
`timescale 1ns / 1ps

package srbo_pkg;

   // Storage geometry
   localparam int DEPTH       = 1024;
   localparam int ADDR_BITS   = 10;
   localparam int CNT_BITS    = 11;
   localparam int SAMPLE_BITS = 32;

   localparam logic [CNT_BITS-1:0] CAP_MAX   = CNT_BITS'(DEPTH);
   localparam logic [CNT_BITS-1:0] CAP_RESET = CNT_BITS'(1024);

   // Command codes
   localparam logic [2:0] CMD_WRITE   = 3'd0;
   localparam logic [2:0] CMD_ACQUIRE = 3'd1;
   localparam logic [2:0] CMD_READ    = 3'd2;
   localparam logic [2:0] CMD_CONSUME = 3'd3;
   localparam logic [2:0] CMD_DISCARD = 3'd4;

   // Status codes
   localparam logic STAT_OK     = 1'b0;
   localparam logic STAT_MISUSE = 1'b1;

   // Request word
   typedef struct packed {
      logic [2:0]             cmd;
      logic [SAMPLE_BITS-1:0] sample_in;
      logic [ADDR_BITS-1:0]   span_index;
      logic [CNT_BITS-1:0]    consume_count;
   } srbo_req_type;

   // Response word
   typedef struct packed {
      logic                   status;
      logic [SAMPLE_BITS-1:0] sample_out;
      logic [ADDR_BITS-1:0]   span_offset;
      logic [CNT_BITS-1:0]    span_length;
      logic [CNT_BITS-1:0]    queued_count;
      logic [31:0]            overrun_total;
   } srbo_rsp_type;

   // Memory access from control to sample store
   typedef struct packed {
      logic                   wr_en;
      logic [ADDR_BITS-1:0]   wr_addr;
      logic [SAMPLE_BITS-1:0] wr_data;
      logic                   rd_en;
      logic [ADDR_BITS-1:0]   rd_addr;
   } srbo_mem_type;

   // Per-command result fields, sample word excluded
   typedef struct packed {
      logic                   status;
      logic                   rd_ok;
      logic [ADDR_BITS-1:0]   span_offset;
      logic [CNT_BITS-1:0]    span_length;
      logic [CNT_BITS-1:0]    queued_count;
      logic [31:0]            overrun_total;
   } srbo_stat_type;

endpackage

// ===== rtl/core/srbo_store.sv =====
// Sample store: single write port, one registered read port.
`timescale 1ns / 1ps

module srbo_store (
   input  logic                                 clock,
   input  srbo_pkg::srbo_mem_type               mem_req,
   output logic [srbo_pkg::SAMPLE_BITS-1:0]     rd_data
);

   logic [srbo_pkg::SAMPLE_BITS-1:0] store_mem [srbo_pkg::DEPTH];
   logic [srbo_pkg::SAMPLE_BITS-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= store_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/srbo_ctrl.sv =====
// Ring buffer control: slot pointers, fill level, span lock and overrun count.
`timescale 1ns / 1ps

module srbo_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  srbo_pkg::srbo_req_type               req,
   input  logic                                 csr_wr_en,
   input  logic [srbo_pkg::CNT_BITS-1:0]        csr_wr_data,
   output srbo_pkg::srbo_mem_type               mem_req,
   output srbo_pkg::srbo_stat_type              stat
);

   localparam int AB = srbo_pkg::ADDR_BITS;
   localparam int CB = srbo_pkg::CNT_BITS;

   logic [AB-1:0] read_slot_ff,  read_slot_in;
   logic [AB-1:0] write_slot_ff, write_slot_in;
   logic [CB-1:0] fill_ff,       fill_in;
   logic [CB-1:0] lock_len_ff,   lock_len_in;
   logic [AB-1:0] lock_off_ff,   lock_off_in;
   logic [31:0]   dropped_ff,    dropped_in;
   logic [CB-1:0] cap_ff,        cap_in;

   logic [CB-1:0] ws_inc, rs_inc, room, span_len, take, rs_adv;
   logic          err, rd_ok, wr_en;

   // Capacity clamp for register writes
   always_comb begin
      if (csr_wr_data == '0) begin
         cap_in = CB'(1);
      end else if (csr_wr_data > srbo_pkg::CAP_MAX) begin
         cap_in = srbo_pkg::CAP_MAX;
      end else begin
         cap_in = csr_wr_data;
      end
   end

   // Next state per command
   always_comb begin
      read_slot_in  = read_slot_ff;
      write_slot_in = write_slot_ff;
      fill_in       = fill_ff;
      lock_len_in   = lock_len_ff;
      lock_off_in   = lock_off_ff;
      dropped_in    = dropped_ff;
      err           = srbo_pkg::STAT_OK;
      rd_ok         = 1'b0;
      wr_en         = 1'b0;
      span_len      = '0;

      ws_inc = {1'b0, write_slot_ff} + CB'(1);
      rs_inc = {1'b0, read_slot_ff} + CB'(1);
      room   = ({1'b0, read_slot_ff} < cap_ff) ? cap_ff - {1'b0, read_slot_ff} : '0;
      take   = (req.consume_count < fill_ff) ? req.consume_count : fill_ff;
      rs_adv = {1'b0, read_slot_ff} + take;
      if (rs_adv >= cap_ff) begin
         rs_adv = rs_adv - cap_ff;
      end
      if (rs_adv >= cap_ff) begin
         rs_adv = '0;
      end

      case (req.cmd)
         srbo_pkg::CMD_WRITE: begin
            wr_en         = 1'b1;
            write_slot_in = (ws_inc >= cap_ff) ? '0 : ws_inc[AB-1:0];
            if (fill_ff >= cap_ff) begin
               // full: drop the oldest sample
               read_slot_in = (rs_inc >= cap_ff) ? '0 : rs_inc[AB-1:0];
               fill_in      = cap_ff;
               if (dropped_ff != '1) begin
                  dropped_in = dropped_ff + 32'd1;
               end
            end else begin
               fill_in = fill_ff + CB'(1);
            end
         end
         srbo_pkg::CMD_ACQUIRE: begin
            if (lock_len_ff != '0) begin
               err = srbo_pkg::STAT_MISUSE;
            end else begin
               span_len    = (fill_ff < room) ? fill_ff : room;
               lock_off_in = read_slot_ff;
               lock_len_in = span_len;
            end
         end
         srbo_pkg::CMD_READ: begin
            if ({1'b0, req.span_index} >= lock_len_ff) begin
               err = srbo_pkg::STAT_MISUSE;
            end else begin
               rd_ok = 1'b1;
            end
         end
         srbo_pkg::CMD_CONSUME: begin
            if (req.consume_count > lock_len_ff) begin
               err = srbo_pkg::STAT_MISUSE;
            end else begin
               read_slot_in = rs_adv[AB-1:0];
               fill_in      = fill_ff - take;
               lock_len_in  = '0;
            end
         end
         srbo_pkg::CMD_DISCARD: begin
            if (lock_len_ff != '0) begin
               err = srbo_pkg::STAT_MISUSE;
            end else begin
               read_slot_in  = '0;
               write_slot_in = '0;
               fill_in       = '0;
            end
         end
         default: begin
            err = srbo_pkg::STAT_MISUSE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         read_slot_ff  <= '0;
         write_slot_ff <= '0;
         fill_ff       <= '0;
         lock_len_ff   <= '0;
         lock_off_ff   <= '0;
         dropped_ff    <= '0;
         cap_ff        <= (srbo_pkg::CAP_RESET > srbo_pkg::CAP_MAX) ?
                          srbo_pkg::CAP_MAX : srbo_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         // capacity change empties the buffer and drops the lock
         cap_ff        <= cap_in;
         read_slot_ff  <= '0;
         write_slot_ff <= '0;
         fill_ff       <= '0;
         lock_len_ff   <= '0;
         lock_off_ff   <= '0;
      end else if (accept) begin
         read_slot_ff  <= read_slot_in;
         write_slot_ff <= write_slot_in;
         fill_ff       <= fill_in;
         lock_len_ff   <= lock_len_in;
         lock_off_ff   <= lock_off_in;
         dropped_ff    <= dropped_in;
      end
   end

   // Memory access
   assign mem_req.wr_en   = accept & wr_en;
   assign mem_req.wr_addr = write_slot_ff;
   assign mem_req.wr_data = req.sample_in;
   assign mem_req.rd_en   = accept & rd_ok;
   assign mem_req.rd_addr = lock_off_ff + req.span_index;

   // Result fields
   assign stat.status        = err;
   assign stat.rd_ok         = rd_ok;
   assign stat.span_offset   = (req.cmd == srbo_pkg::CMD_ACQUIRE && !err) ? read_slot_ff : '0;
   assign stat.span_length   = span_len;
   assign stat.queued_count  = fill_in;
   assign stat.overrun_total = dropped_in;

endmodule

// ===== rtl/core/sample_ring_buffer_overwrite_unit.sv =====
// Top level of the overwriting sample ring buffer.
// Usage: one request word per command on req_ (write, acquire, read, consume,
// discard); exactly one response word per request on rsp_. A word moves when
// valid is high and stall is low. csr_wr_en with csr_wr_data sets the slot
// capacity (0 acts as 1, above 1024 acts as 1024) and empties the buffer.
// The command is decoded and the state updated at the accepting edge, and
// the response register (plus the registered read port of the sample memory)
// holds the result in the next cycle.
// Throughput is one word per cycle, bounded by the single memory access per
// command; a new request is taken whenever the response register is empty or
// being drained in the same cycle.
// While rsp_stall holds a pending response, req_stall is raised and the
// response word stays unchanged.
// Reset clears pointers, fill level, lock and overrun count and sets capacity
// to 1024; sample memory contents are not cleared.
`timescale 1ns / 1ps

module sample_ring_buffer_overwrite_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  srbo_pkg::srbo_req_type               req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output srbo_pkg::srbo_rsp_type               rsp_word,
   input  logic                                 csr_wr_en,
   input  logic [srbo_pkg::CNT_BITS-1:0]        csr_wr_data
);

   logic                             accept;
   logic                             rsp_valid_ff, rsp_valid_in;
   srbo_pkg::srbo_stat_type          stat;
   srbo_pkg::srbo_stat_type          stat_ff;
   srbo_pkg::srbo_mem_type           mem_req;
   logic [srbo_pkg::SAMPLE_BITS-1:0] rd_data;

   // Handshake
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   srbo_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_req     (mem_req),
      .stat        (stat)
   );

   srbo_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         stat_ff <= stat;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_word.status        = stat_ff.status;
   assign rsp_word.sample_out    = stat_ff.rd_ok ? rd_data : '0;
   assign rsp_word.span_offset   = stat_ff.span_offset;
   assign rsp_word.span_length   = stat_ff.span_length;
   assign rsp_word.queued_count  = stat_ff.queued_count;
   assign rsp_word.overrun_total = stat_ff.overrun_total;

endmodule
